// ===== src/isr_pkg.sv =====
`timescale 1ns / 1ps

package isr_pkg;

    // width of each root field on the result channel
    localparam int OUT_BITS = 16;

endpackage

// ===== src/integer_square_root_unit.sv =====
`timescale 1ns / 1ps

// channel   handshake                       payload
// input     radicand_valid / radicand_ready radicand
// result    result_valid / result_ready     floor_root, ceil_root
//
// a row of (INPUT_BITS+1)/2 cells (16 at INPUT_BITS = 31), one root digit per cell;
// a new transfer can enter every cycle while radicand_ready is high
// each cell holds its item until the next cell frees up, so a stalled result
// only backs up the cells behind it; empty cells still take new transfers
// reset clears the cell valid bits only

module integer_square_root_unit #(
    parameter int INPUT_BITS = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radicand_valid,
    output logic                         radicand_ready,
    input  logic [INPUT_BITS-1:0]        radicand,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [isr_pkg::OUT_BITS-1:0] floor_root,
    output logic [isr_pkg::OUT_BITS-1:0] ceil_root
);

    localparam int Digits = (INPUT_BITS + 1) / 2;
    localparam int RadW   = 2 * Digits;
    localparam int RemW   = Digits + 1;
    localparam int OutW   = isr_pkg::OUT_BITS;

    logic              valid_w [Digits+1];
    logic              ready_w [Digits+1];
    logic [RadW-1:0]   rad_w   [Digits+1];
    logic [RemW-1:0]   rem_w   [Digits+1];
    logic [Digits-1:0] root_w  [Digits+1];
    logic [Digits:0]   ceil_full;
    logic              inexact;

    assign valid_w[0]     = radicand_valid;
    assign radicand_ready = ready_w[0];
    assign rad_w[0]       = RadW'(radicand);
    assign rem_w[0]       = '0;
    assign root_w[0]      = '0;
    assign ready_w[Digits] = result_ready;

    for (genvar i = 0; i < Digits; i++)
    begin : g_cell
        isr_cell #(
            .DIGITS (Digits)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_w[i]),
            .ready_out (ready_w[i]),
            .rad_in    (rad_w[i]),
            .rem_in    (rem_w[i]),
            .root_in   (root_w[i]),
            .valid_out (valid_w[i+1]),
            .ready_in  (ready_w[i+1]),
            .rad_out   (rad_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .root_out  (root_w[i+1])
        );
    end

    // non-zero remainder means the radicand is not a perfect square
    assign inexact   = (rem_w[Digits] != '0) && (rad_w[Digits] == '0);
    assign ceil_full = (Digits+1)'(root_w[Digits]) + (Digits+1)'(inexact);

    assign result_valid = valid_w[Digits];
    assign floor_root   = OutW'(root_w[Digits]);
    assign ceil_root    = OutW'(ceil_full);

endmodule

// ===== src/isr_cell.sv =====
`timescale 1ns / 1ps

module isr_cell #(
    parameter int DIGITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    output logic                ready_out,
    input  logic [2*DIGITS-1:0] rad_in,
    input  logic [DIGITS:0]     rem_in,
    input  logic [DIGITS-1:0]   root_in,
    output logic                valid_out,
    input  logic                ready_in,
    output logic [2*DIGITS-1:0] rad_out,
    output logic [DIGITS:0]     rem_out,
    output logic [DIGITS-1:0]   root_out
);

    localparam int RadW   = 2 * DIGITS;
    localparam int RemW   = DIGITS + 1;
    localparam int WorkW  = DIGITS + 3;

    logic                valid_reg;
    logic                valid_next;
    logic [RadW-1:0]     rad_reg;
    logic [RadW-1:0]     rad_next;
    logic [RemW-1:0]     rem_reg;
    logic [RemW-1:0]     rem_next;
    logic [DIGITS-1:0]   root_reg;
    logic [DIGITS-1:0]   root_next;
    logic                load;
    logic [WorkW-1:0]    partial;
    logic [WorkW-1:0]    trial;
    logic [WorkW-1:0]    diff;
    logic                fits;
    logic [DIGITS:0]     root_shift;

    // stage takes a new digit when empty or when its content moves on
    assign load      = !valid_reg || ready_in;
    assign ready_out = load;

    always_comb
    begin
        // bring down the next two radicand bits and try root*4+1
        partial    = {rem_in, rad_in[RadW-1 -: 2]};
        trial      = WorkW'({root_in, 2'b01});
        fits       = (partial >= trial);
        diff       = partial - trial;
        root_shift = {root_in, fits};
        valid_next = valid_in;
        rad_next   = rad_in << 2;
        rem_next   = fits ? diff[RemW-1:0] : partial[RemW-1:0];
        root_next  = root_shift[DIGITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule
